// File: rtl/core/ir_transponder_frame_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// ir_transponder_frame_encoder_top_assert.svh
// assertion macros shared by the rtl, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef IR_TRANSPONDER_FRAME_ENCODER_TOP_ASSERT_SVH
`define IR_TRANSPONDER_FRAME_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTH
// checked once reset is released
`define IRTFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("irtfe assertion failed");
// checked on every edge, reset included
`define IRTFE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("irtfe assertion failed");
`else
`define IRTFE_ASSERT(lbl, clk, rstn, prop)
`define IRTFE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/irtfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtfe_pkg
// widths, frame layout and symbol timing of the ir frame encoder
// ----------------------------------------------------------------------------
package irtfe_pkg;

    localparam int IdW    = 24;
    localparam int TicksW = 4;
    localparam int CrcW   = 8;
    localparam int PosW   = 4;
    localparam int ByteW  = 2;

    localparam logic [CrcW-1:0] CRC_POLY = 8'h07;

    // bit positions inside one 11-bit byte frame
    localparam logic [PosW-1:0] POS_START     = 4'd0;
    localparam logic [PosW-1:0] POS_DATA_LAST = 4'd8;
    localparam logic [PosW-1:0] POS_PARITY    = 4'd9;
    localparam logic [PosW-1:0] POS_STOP      = 4'd10;

    // the crc byte goes out last
    localparam logic [ByteW-1:0] BYTE_CRC = 2'd3;

    // symbol shapes in 1 us ticks
    localparam logic [TicksW-1:0] STOP_FIRST  = 4'd3;
    localparam logic [TicksW-1:0] STOP_SECOND = 4'd2;
    localparam logic [TicksW-1:0] ONE_FIRST   = 4'd5;
    localparam logic [TicksW-1:0] ONE_SECOND  = 4'd5;
    localparam logic [TicksW-1:0] ZERO_FIRST  = 4'd2;
    localparam logic [TicksW-1:0] ZERO_SECOND = 4'd8;

    typedef struct packed {
        logic [TicksW-1:0] first_ticks;
        logic              first_level;
        logic [TicksW-1:0] second_ticks;
        logic              second_level;
        logic              frame_bit;
        logic              last_symbol;
    } t_symbol;

endpackage

// File: rtl/core/irtfe_id_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtfe_id_if
// valid/ready channel carrying one transponder id per beat
// ----------------------------------------------------------------------------
interface irtfe_id_if
    import irtfe_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [IdW-1:0] transponder_id;

    modport source (output valid, output transponder_id, input ready);
    modport sink   (input valid, input transponder_id, output ready);
endinterface

// File: rtl/core/irtfe_sym_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtfe_sym_if
// valid/ready channel carrying one pulse symbol per beat
// ----------------------------------------------------------------------------
interface irtfe_sym_if
    import irtfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TicksW-1:0] first_ticks;
    logic              first_level;
    logic [TicksW-1:0] second_ticks;
    logic              second_level;
    logic              frame_bit;
    logic              last_symbol;

    modport source (
        output valid, output first_ticks, output first_level,
        output second_ticks, output second_level, output frame_bit,
        output last_symbol, input ready
    );
    modport sink (
        input valid, input first_ticks, input first_level,
        input second_ticks, input second_level, input frame_bit,
        input last_symbol, output ready
    );
endinterface

// File: rtl/core/ir_transponder_frame_encoder_top.sv
`timescale 1ns / 1ps
// Each accepted 24-bit id turns into 44 pulse symbols: four 11-bit byte frames (start, 8 data
// bits msb first, even parity, stop) for id[7:0], id[15:8], id[23:16] and their crc-8 (poly
// 0x07, init 0). After the id is loaded, one symbol leaves the shift register per cycle while
// the output side takes them; the next id is taken once the last symbol sits in the output
// register. The crc and parity are built one bit per cycle as the id bits go out, while the
// output side takes symbols, and the crc is done before its own byte starts.
// ----------------------------------------------------------------------------
// ir_transponder_frame_encoder_top
// bit-serial crc-8 and parity framing of a transponder id into ir pulse symbols
// ----------------------------------------------------------------------------
`include "ir_transponder_frame_encoder_top_assert.svh"

module ir_transponder_frame_encoder_top
    import irtfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    irtfe_id_if.sink    i_id,
    irtfe_sym_if.source o_sym
);

    logic [IdW-1:0]   r_data, n_data;
    logic [CrcW-1:0]  r_crc, n_crc;
    logic             r_par, n_par;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [ByteW-1:0] r_byte, n_byte;
    logic             r_busy, n_busy;
    logic             r_out_valid, n_out_valid;
    t_symbol          r_out, n_out;

    logic load;
    logic step;
    logic is_data;
    logic data_bit;
    logic sym_bit;
    logic fb;

    assign i_id.ready = !r_busy;
    assign load = i_id.valid && !r_busy;
    assign step = r_busy && (!r_out_valid || o_sym.ready);

    always_comb begin
        is_data  = (r_pos != POS_START) && (r_pos <= POS_DATA_LAST);
        data_bit = (r_byte == BYTE_CRC) ? r_crc[CrcW-1] : r_data[IdW-1];
        fb       = r_crc[CrcW-1] ^ data_bit;
        priority if (r_pos == POS_START) begin
            sym_bit = 1'b0;
        end else if (is_data) begin
            sym_bit = data_bit;
        end else if (r_pos == POS_PARITY) begin
            sym_bit = r_par;
        end else begin
            sym_bit = 1'b1;
        end
    end

    always_comb begin
        n_data      = r_data;
        n_crc       = r_crc;
        n_par       = r_par;
        n_pos       = r_pos;
        n_byte      = r_byte;
        n_busy      = r_busy;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_sym.ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            // byte order on the wire: low id byte first
            n_data = {i_id.transponder_id[7:0], i_id.transponder_id[15:8],
                      i_id.transponder_id[23:16]};
            n_crc  = '0;
            n_par  = 1'b0;
            n_pos  = POS_START;
            n_byte = '0;
            n_busy = 1'b1;
        end else if (step) begin
            if (r_pos == POS_START) begin
                n_par = 1'b0;
            end
            if (is_data) begin
                n_par = r_par ^ data_bit;
                if (r_byte == BYTE_CRC) begin
                    n_crc = {r_crc[CrcW-2:0], 1'b0};
                end else begin
                    n_data = {r_data[IdW-2:0], 1'b0};
                    n_crc  = {r_crc[CrcW-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
                end
            end
            if (r_pos == POS_STOP) begin
                n_pos  = POS_START;
                n_byte = r_byte + 1'b1;
                if (r_byte == BYTE_CRC) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
            n_out_valid        = 1'b1;
            n_out.frame_bit    = sym_bit;
            n_out.second_level = 1'b0;
            n_out.last_symbol  = (r_pos == POS_STOP) && (r_byte == BYTE_CRC);
            priority if (r_pos == POS_STOP) begin
                n_out.first_ticks  = STOP_FIRST;
                n_out.first_level  = 1'b0;
                n_out.second_ticks = STOP_SECOND;
            end else if (sym_bit) begin
                n_out.first_ticks  = ONE_FIRST;
                n_out.first_level  = 1'b0;
                n_out.second_ticks = ONE_SECOND;
            end else begin
                n_out.first_ticks  = ZERO_FIRST;
                n_out.first_level  = 1'b1;
                n_out.second_ticks = ZERO_SECOND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= POS_START;
            r_byte      <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_byte      <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_crc  <= n_crc;
        r_par  <= n_par;
        r_out  <= n_out;
    end

    assign o_sym.valid        = r_out_valid;
    assign o_sym.first_ticks  = r_out.first_ticks;
    assign o_sym.first_level  = r_out.first_level;
    assign o_sym.second_ticks = r_out.second_ticks;
    assign o_sym.second_level = r_out.second_level;
    assign o_sym.frame_bit    = r_out.frame_bit;
    assign o_sym.last_symbol  = r_out.last_symbol;

    // an accepted id always starts a frame
    `IRTFE_ASSERT(a_load_busy, i_clk, i_rst_n, load |=> r_busy && r_pos == POS_START)
    // counters are parked at the frame start while idle
    `IRTFE_ASSERT(a_idle_parked, i_clk, i_rst_n, !r_busy |-> r_pos == POS_START && r_byte == 2'd0)
    // a frame ends exactly when its last symbol is loaded
    `IRTFE_ASSERT(a_end_last, i_clk, i_rst_n, $fell(r_busy) |-> r_out_valid && r_out.last_symbol)
    // the last symbol is a stop bit
    `IRTFE_ASSERT(a_last_stop, i_clk, i_rst_n, r_out_valid && r_out.last_symbol |-> r_out.frame_bit && r_out.first_ticks == STOP_FIRST)

endmodule

// File: test/tb_irtfe_symbol_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_irtfe_symbol_check
// watches the id and symbol channels, works out the 44 pulse symbols of every
// accepted id and compares each symbol beat against the oldest one still due
// ----------------------------------------------------------------------------
module tb_irtfe_symbol_check
    import irtfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    irtfe_id_if  i_id_mon,
    irtfe_sym_if i_sym_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int FrameBits = 44;
    localparam int ByteBits  = 11;

    t_symbol symbols_due[$];
    int      mismatches = 0;

    // crc-8, poly 0x07, msb first, one byte folded in
    function automatic logic [CrcW-1:0] crc8_fold(input logic [CrcW-1:0] crc,
                                                  input logic [7:0] data);
        logic [CrcW-1:0] c;
        c = crc ^ data;
        for (int n = 0; n < 8; n++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // start 0, data msb first, odd-count parity, stop 1 for each of the four bytes
    function automatic logic [FrameBits-1:0] id_frame(input logic [IdW-1:0] id);
        logic [7:0]           frame_bytes [4];
        logic [FrameBits-1:0] f;
        frame_bytes[0] = id[7:0];
        frame_bytes[1] = id[15:8];
        frame_bytes[2] = id[23:16];
        frame_bytes[3] = crc8_fold(crc8_fold(crc8_fold(8'h00, id[7:0]), id[15:8]),
                                   id[23:16]);
        f = '0;
        for (int i = 0; i < 4; i++) begin
            f = {f[FrameBits-ByteBits-1:0], 1'b0, frame_bytes[i], ^frame_bytes[i], 1'b1};
        end
        return f;
    endfunction

    task automatic queue_frame_symbols(input logic [IdW-1:0] id);
        logic [FrameBits-1:0] f;
        t_symbol              s;
        logic                 b;
        f = id_frame(id);
        for (int k = 0; k < FrameBits; k++) begin
            b = f[FrameBits-1-k];
            if (k % ByteBits == ByteBits - 1) begin
                s.first_ticks  = STOP_FIRST;
                s.first_level  = 1'b0;
                s.second_ticks = STOP_SECOND;
            end else if (b) begin
                s.first_ticks  = ONE_FIRST;
                s.first_level  = 1'b0;
                s.second_ticks = ONE_SECOND;
            end else begin
                s.first_ticks  = ZERO_FIRST;
                s.first_level  = 1'b1;
                s.second_ticks = ZERO_SECOND;
            end
            s.second_level = 1'b0;
            s.frame_bit    = b;
            s.last_symbol  = (k == FrameBits - 1);
            symbols_due.push_back(s);
        end
    endtask

    task automatic check_field(input string name, input logic [TicksW-1:0] exp_val,
                               input logic [TicksW-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_symbol want;
        if (i_rst_n) begin
            // compare before queuing so a new frame never answers an early beat
            if (i_sym_mon.valid && i_sym_mon.ready) begin
                if (symbols_due.size() == 0) begin
                    $error("symbol beat with no symbol due");
                    mismatches++;
                end else begin
                    want = symbols_due.pop_front();
                    check_field("first_ticks", want.first_ticks, i_sym_mon.first_ticks);
                    check_field("first_level", want.first_level, i_sym_mon.first_level);
                    check_field("second_ticks", want.second_ticks, i_sym_mon.second_ticks);
                    check_field("second_level", want.second_level, i_sym_mon.second_level);
                    check_field("frame_bit", want.frame_bit, i_sym_mon.frame_bit);
                    check_field("last_symbol", want.last_symbol, i_sym_mon.last_symbol);
                end
            end
            if (i_id_mon.valid && i_id_mon.ready) begin
                queue_frame_symbols(i_id_mon.transponder_id);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= symbols_due.size();
    end

endmodule

// File: test/tb_ir_transponder_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_transponder_frame_encoder_top
// feeds directed and random transponder ids with random gaps and output
// stalls, and gives the verdict from the symbol checker
// ----------------------------------------------------------------------------
module tb_ir_transponder_frame_encoder_top
    import irtfe_pkg::*;
();

    localparam int RandomIds  = 250;
    localparam int CycleLimit = 1_500_000;
    localparam int DrainWait  = 60;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   ready_hold;
    int   cycle_count;
    int   fail_count;
    int   pending;

    irtfe_id_if  id_ch ();
    irtfe_sym_if sym_ch ();

    ir_transponder_frame_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_id    (id_ch),
        .o_sym   (sym_ch)
    );

    tb_irtfe_symbol_check symbol_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_id_mon     (id_ch),
        .i_sym_mon    (sym_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int source_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 30);
    endfunction

    function automatic int stall_len();
        return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(10, 30);
    endfunction

    always @(posedge i_clk) begin
        if (!idle_on) begin
            sym_ch.ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (sym_ch.ready) begin
            if ($urandom_range(0, 99) < 30) begin
                sym_ch.ready <= 1'b0;
                ready_hold = stall_len() - 1;
            end
        end else begin
            sym_ch.ready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_id(input logic [IdW-1:0] id, input int gap);
        if (gap > 0) begin
            id_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        id_ch.valid          <= 1'b1;
        id_ch.transponder_id <= id;
        @(posedge i_clk);
        while (!id_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 2))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [IdW-1:0] random_id();
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 9);
        b = 8'($urandom());
        if (r < 6) return IdW'($urandom());
        if (r == 6) return IdW'(1) << $urandom_range(0, IdW - 1);
        if (r == 7) return ~(IdW'(1) << $urandom_range(0, IdW - 1));
        if (r == 8) return {pick_byte(), pick_byte(), pick_byte()};
        return {b, b, b};
    endfunction

    initial begin
        logic [IdW-1:0] directed_ids [$];
        idle_on              = 1'b0;
        i_rst_n              = 1'b0;
        id_ch.valid          = 1'b0;
        id_ch.transponder_id = '0;
        directed_ids = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h0000FF,
                         24'h00FF00, 24'hFF0000, 24'h000080, 24'h010000, 24'hAAAAAA,
                         24'h555555, 24'h0F0F0F, 24'hF0F0F0, 24'h123456, 24'h7FFFFF,
                         24'hFFFFFE, 24'h00FFFF, 24'hFE01C3};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first ids back to back so each frame follows a finished one at once
        foreach (directed_ids[i]) begin
            if (i == 8) idle_on = 1'b1;
            send_id(directed_ids[i], source_gap());
        end

        // every third stretch of 40 ids runs with no gaps and no stalls
        for (int i = 0; i < RandomIds; i++) begin
            idle_on = ((i / 40) % 3 != 2);
            send_id(random_id(), source_gap());
        end
        id_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
